// ===== hdl/att_pkg.sv =====
// ----------------------------------------------------------------------------
// att_pkg
// Shared widths, constants and helpers for the accelerometer tilt-angle block.
// ----------------------------------------------------------------------------
package att_pkg;

  localparam int unsigned SAMPLE_WIDTH    = 16;
  localparam int unsigned ANGLE_FRAC_BITS = 8;
  localparam int unsigned OUT_W           = 16;

  // magnitude of a sample, sum of two squares
  localparam int unsigned MAG_W = SAMPLE_WIDTH;
  localparam int unsigned SQ_W  = 2 * SAMPLE_WIDTH - 1;
  localparam int unsigned S_W   = 2 * SAMPLE_WIDTH;
  localparam int unsigned LEN_W = $clog2(S_W + 1);

  // normalised operands: radicand below 2^62, numerator below 2^40
  localparam int unsigned RAD_W      = 62;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned VY_W       = 40;
  localparam int unsigned P_W        = 5;
  localparam int unsigned P_MAX      = 29;
  localparam int unsigned SQRT_STEPS = ROOT_W;

  // CORDIC datapath
  localparam int unsigned CW          = 44;
  localparam int unsigned ACC_W       = 26;
  localparam int unsigned ATAN_STEPS  = 23;
  localparam int unsigned ACC_FRAC    = 16;
  localparam logic [ACC_W-1:0] RIGHT_ANGLE = ACC_W'(90) << ACC_FRAC;

  localparam logic [ACC_W-1:0] ATAN_TAB [ATAN_STEPS] = '{
    ACC_W'(2949120), ACC_W'(1740967), ACC_W'(919879), ACC_W'(466945),
    ACC_W'(234379),  ACC_W'(117304),  ACC_W'(58666),  ACC_W'(29335),
    ACC_W'(14668),   ACC_W'(7334),    ACC_W'(3667),   ACC_W'(1833),
    ACC_W'(917),     ACC_W'(458),     ACC_W'(229),    ACC_W'(115),
    ACC_W'(57),      ACC_W'(29),      ACC_W'(14),     ACC_W'(7),
    ACC_W'(4),       ACC_W'(2),       ACC_W'(1)
  };

  localparam int unsigned FRONT_STAGES  = 2;
  localparam int unsigned SQRT_STAGES   = 1 + SQRT_STEPS;
  localparam int unsigned CORDIC_STAGES = ATAN_STEPS + 1;
  localparam int unsigned PIPE_DEPTH    = FRONT_STAGES + SQRT_STAGES + CORDIC_STAGES;

  typedef struct packed {
    logic za;    // numerator is zero
    logic zs;    // radicand is zero
    logic neg;   // negate the result
    logic comp;  // result is the complement to ninety degrees
  } lane_flags_t;

  function automatic logic [LEN_W-1:0] bit_len(input logic [S_W-1:0] v);
    logic [LEN_W-1:0] len;
    len = '0;
    for (int i = 0; i < S_W; i++) begin
      if (v[i]) len = LEN_W'(i + 1);
    end
    return len;
  endfunction

endpackage

// ===== hdl/att_ifs.sv =====
// ----------------------------------------------------------------------------
// att_ifs
// Sample request channel and tilt result channel.
// ----------------------------------------------------------------------------
interface att_in_if;
  import att_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface att_out_if;
  import att_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] tilt_x;
  logic signed [OUT_W-1:0] tilt_y;
  logic signed [OUT_W-1:0] tilt_z;

  modport source (output valid, tilt_x, tilt_y, tilt_z, input ready);
  modport sink   (input valid, tilt_x, tilt_y, tilt_z, output ready);
endinterface

// ===== hdl/att_front.sv =====
// ----------------------------------------------------------------------------
// att_front
// Sample magnitudes and signs, then squares and per-lane radicands.
// ----------------------------------------------------------------------------
module att_front (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [att_pkg::SAMPLE_WIDTH-1:0] x_i,
  input  logic signed [att_pkg::SAMPLE_WIDTH-1:0] y_i,
  input  logic signed [att_pkg::SAMPLE_WIDTH-1:0] z_i,
  output logic [att_pkg::MAG_W-1:0]         a_o     [3],
  output logic [att_pkg::S_W-1:0]           s_o     [3],
  output att_pkg::lane_flags_t              flags_o [3]
);
  import att_pkg::*;

  logic [MAG_W-1:0] m_q   [3];
  logic             neg_q [3];
  logic [SQ_W-1:0]  sq    [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]   <= x_i[SAMPLE_WIDTH-1] ? MAG_W'(-x_i) : MAG_W'(x_i);
      m_q[1]   <= y_i[SAMPLE_WIDTH-1] ? MAG_W'(-y_i) : MAG_W'(y_i);
      m_q[2]   <= z_i[SAMPLE_WIDTH-1] ? MAG_W'(-z_i) : MAG_W'(z_i);
      neg_q[0] <= x_i[SAMPLE_WIDTH-1];
      neg_q[1] <= y_i[SAMPLE_WIDTH-1];
      neg_q[2] <= z_i[SAMPLE_WIDTH-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq[i] = SQ_W'(S_W'(m_q[i]) * S_W'(m_q[i]));
    end
  end

  // lane k: numerator is axis k, radicand the other two squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o[0] <= m_q[0];
      a_o[1] <= m_q[1];
      a_o[2] <= m_q[2];
      s_o[0] <= S_W'(sq[1]) + S_W'(sq[2]);
      s_o[1] <= S_W'(sq[0]) + S_W'(sq[2]);
      s_o[2] <= S_W'(sq[0]) + S_W'(sq[1]);
      flags_o[0] <= '{za: (m_q[0] == '0), zs: (m_q[1] == '0) && (m_q[2] == '0),
                      neg: neg_q[0], comp: 1'b0};
      flags_o[1] <= '{za: (m_q[1] == '0), zs: (m_q[0] == '0) && (m_q[2] == '0),
                      neg: neg_q[1], comp: 1'b0};
      flags_o[2] <= '{za: (m_q[2] == '0), zs: (m_q[0] == '0) && (m_q[1] == '0),
                      neg: neg_q[2], comp: 1'b1};
    end
  end

endmodule

// ===== hdl/att_sqrt.sv =====
// ----------------------------------------------------------------------------
// att_sqrt
// Operand normalisation and a pipelined restoring square root, one root
// bit per stage.
// ----------------------------------------------------------------------------
module att_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [att_pkg::MAG_W-1:0]    a_i,
  input  logic [att_pkg::S_W-1:0]      s_i,
  input  att_pkg::lane_flags_t         flags_i,
  output logic [att_pkg::ROOT_W-1:0]   root_o,
  output logic [att_pkg::VY_W-1:0]     vy_o,
  output att_pkg::lane_flags_t         flags_o
);
  import att_pkg::*;

  logic [LEN_W-1:0]  len_s, len_a;
  logic [6:0]        p_s, p_a, p_min;
  logic [P_W-1:0]    p;

  logic [RAD_W-1:0]  rem_q   [SQRT_STEPS];
  logic [ROOT_W-1:0] root_q  [SQRT_STEPS+1];
  logic [VY_W-1:0]   vy_q    [SQRT_STEPS+1];
  lane_flags_t       flags_q [SQRT_STEPS+1];

  // largest shift below 30 keeping radicand < 2^62 and numerator < 2^40
  always_comb begin
    len_s = bit_len(s_i);
    len_a = bit_len(S_W'(a_i));
    p_s   = ((7'd60 - 7'(len_s)) >> 1) + 7'd1;
    p_a   = 7'd40 - 7'(len_a);
    p_min = 7'(P_MAX);
    if (p_s < p_min) p_min = p_s;
    if (p_a < p_min) p_min = p_a;
    p = P_W'(p_min);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]   <= RAD_W'(s_i) << {p, 1'b0};
      root_q[0]  <= '0;
      vy_q[0]    <= VY_W'(a_i) << p;
      flags_q[0] <= flags_i;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam int unsigned B = SQRT_STEPS - 1 - j;
    logic [RAD_W-1:0] trial;
    logic             take;

    assign trial = (RAD_W'(root_q[j]) << (B + 1)) + (RAD_W'(1) << (2 * B));
    assign take  = rem_q[j] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[j+1]  <= take ? (root_q[j] | (ROOT_W'(1) << B)) : root_q[j];
        vy_q[j+1]    <= vy_q[j];
        flags_q[j+1] <= flags_q[j];
      end
    end

    if (j < SQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1] <= take ? (rem_q[j] - trial) : rem_q[j];
        end
      end
    end
  end

  assign root_o  = root_q[SQRT_STEPS];
  assign vy_o    = vy_q[SQRT_STEPS];
  assign flags_o = flags_q[SQRT_STEPS];

endmodule

// ===== hdl/att_cordic.sv =====
// ----------------------------------------------------------------------------
// att_cordic
// Pipelined CORDIC vectoring, one rotation per stage, then clamp, special
// cases, rounding and sign.
// ----------------------------------------------------------------------------
module att_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [att_pkg::ROOT_W-1:0]        root_i,
  input  logic [att_pkg::VY_W-1:0]          vy_i,
  input  att_pkg::lane_flags_t              flags_i,
  output logic signed [att_pkg::OUT_W-1:0]  tilt_o
);
  import att_pkg::*;

  logic signed [CW-1:0]    vx_q  [ATAN_STEPS-1];
  logic signed [CW-1:0]    vy_q  [ATAN_STEPS-1];
  logic signed [ACC_W-1:0] acc_q [ATAN_STEPS];
  lane_flags_t             fl_q  [ATAN_STEPS];

  for (genvar i = 0; i < ATAN_STEPS; i++) begin : g_rot
    logic signed [CW-1:0]    vx_c, vy_c;
    logic signed [ACC_W-1:0] acc_c;
    lane_flags_t             fl_c;
    logic                    up;

    if (i == 0) begin : g_src
      assign vx_c  = $signed(CW'(root_i));
      assign vy_c  = $signed(CW'(vy_i));
      assign acc_c = '0;
      assign fl_c  = flags_i;
    end else begin : g_src
      assign vx_c  = vx_q[i-1];
      assign vy_c  = vy_q[i-1];
      assign acc_c = acc_q[i-1];
      assign fl_c  = fl_q[i-1];
    end

    assign up = vy_c > 0;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[i] <= up ? acc_c + $signed(ATAN_TAB[i]) : acc_c - $signed(ATAN_TAB[i]);
        fl_q[i]  <= fl_c;
      end
    end

    if (i < ATAN_STEPS - 1) begin : g_vec
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          vx_q[i] <= up ? vx_c + (vy_c >>> i) : vx_c - (vy_c >>> i);
          vy_q[i] <= up ? vy_c - (vx_c >>> i) : vy_c + (vx_c >>> i);
        end
      end
    end
  end

  logic signed [ACC_W-1:0] acc;
  lane_flags_t             fl;
  logic [ACC_W-1:0]        ang, mag, rnd;

  always_comb begin
    acc = acc_q[ATAN_STEPS-1];
    fl  = fl_q[ATAN_STEPS-1];
    if (acc < 0) begin
      ang = '0;
    end else if (ACC_W'(acc) > RIGHT_ANGLE) begin
      ang = RIGHT_ANGLE;
    end else begin
      ang = ACC_W'(acc);
    end
    priority if (fl.za) ang = '0;
    else if (fl.zs)     ang = RIGHT_ANGLE;
    else                ang = ang;
    // z lane: complement, except zero over zero which stays zero
    if (fl.comp) mag = (fl.za && fl.zs) ? '0 : RIGHT_ANGLE - ang;
    else         mag = ang;
    rnd = (mag + (ACC_W'(1) << (ACC_FRAC - 1 - ANGLE_FRAC_BITS)))
          >> (ACC_FRAC - ANGLE_FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tilt_o <= fl.neg ? OUT_W'(-rnd) : OUT_W'(rnd);
    end
  end

endmodule

// ===== hdl/accel_tilt_angles.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_angles
// Throughput: one sample per cycle; the whole pipeline holds only while a
// result on out_o is not taken. Stages: 2 front, 32 square root, 24 CORDIC.
// Reset clears the stage valid bits only; the datapath has no reset.
// ----------------------------------------------------------------------------
module accel_tilt_angles (
  input  logic            clk_i,
  input  logic            rst_ni,
  att_in_if.sink          in_i,
  att_out_if.source       out_o
);
  import att_pkg::*;

  logic                    en;
  logic [PIPE_DEPTH-1:0]   vld_q;

  logic [MAG_W-1:0]        a     [3];
  logic [S_W-1:0]          s     [3];
  lane_flags_t             fl_f  [3];
  logic [ROOT_W-1:0]       root  [3];
  logic [VY_W-1:0]         vy    [3];
  lane_flags_t             fl_s  [3];
  logic signed [OUT_W-1:0] tilt  [3];

  assign en = !vld_q[PIPE_DEPTH-1] || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_i.valid};
    end
  end

  att_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (in_i.accel_x),
    .y_i     (in_i.accel_y),
    .z_i     (in_i.accel_z),
    .a_o     (a),
    .s_o     (s),
    .flags_o (fl_f)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    att_sqrt u_sqrt (
      .clk_i   (clk_i),
      .en_i    (en),
      .a_i     (a[k]),
      .s_i     (s[k]),
      .flags_i (fl_f[k]),
      .root_o  (root[k]),
      .vy_o    (vy[k]),
      .flags_o (fl_s[k])
    );

    att_cordic u_cordic (
      .clk_i   (clk_i),
      .en_i    (en),
      .root_i  (root[k]),
      .vy_i    (vy[k]),
      .flags_i (fl_s[k]),
      .tilt_o  (tilt[k])
    );
  end

  assign in_i.ready   = en;
  assign out_o.valid  = vld_q[PIPE_DEPTH-1];
  assign out_o.tilt_x = tilt[0];
  assign out_o.tilt_y = tilt[1];
  assign out_o.tilt_z = tilt[2];

endmodule

// ===== hdl/att_checker.sv =====
// ----------------------------------------------------------------------------
// att_checker
// Port-level checks on the tilt-angle block, bound to the top level.
// ----------------------------------------------------------------------------
module att_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [att_pkg::OUT_W-1:0] tilt_x_i,
  input logic signed [att_pkg::OUT_W-1:0] tilt_y_i,
  input logic signed [att_pkg::OUT_W-1:0] tilt_z_i
);
  import att_pkg::*;

  localparam logic signed [OUT_W-1:0] LIM = OUT_W'(90) <<< ANGLE_FRAC_BITS;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(tilt_x_i) && $stable(tilt_y_i) && $stable(tilt_z_i))
    else $error("result changed while stalled");

  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("sample request refused with output free");

  a_range_xy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> tilt_x_i <= LIM && tilt_x_i >= -LIM &&
                    tilt_y_i <= LIM && tilt_y_i >= -LIM)
    else $error("x or y tilt beyond ninety degrees");

  a_range_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> tilt_z_i <= LIM && tilt_z_i >= -LIM)
    else $error("z tilt beyond ninety degrees");

endmodule

bind accel_tilt_angles att_checker u_att_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .tilt_x_i    (out_o.tilt_x),
  .tilt_y_i    (out_o.tilt_y),
  .tilt_z_i    (out_o.tilt_z)
);

// ===== tb/tb_accel_tilt_angles.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accel_tilt_angles
// Drives accelerometer samples into the tilt-angle pipeline and checks every
// result against a bit-exact software CORDIC predictor, under varied idling.
// ----------------------------------------------------------------------------
module tb_accel_tilt_angles;
  import att_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] x;
    logic signed [SAMPLE_WIDTH-1:0] y;
    logic signed [SAMPLE_WIDTH-1:0] z;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] tx;
    logic signed [OUT_W-1:0] ty;
    logic signed [OUT_W-1:0] tz;
  } tilt_t;

  localparam int unsigned WATCHDOG = 20000;
  localparam longint unsigned RIGHT_DEG16 = 64'd90 << 16;

  logic clk_i;
  logic rst_ni;

  att_in_if  in_ch ();
  att_out_if out_ch ();

  accel_tilt_angles uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  sample_t pending_q[$];
  tilt_t   tilt_q[$];
  int      idle_pct_in;
  int      idle_pct_out;
  int      n_sent;
  int      n_checked;
  int      n_bad;
  int      quiet_cycles;
  bit      timed_out;
  bit      in_taken;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // atan(a / sqrt(s)) in degrees * 2^16, clamped to [0, 90]
  function automatic longint unsigned cordic_deg(input longint unsigned a,
                                                 input longint unsigned s);
    int unsigned p;
    longint vx, vy, acc, dx, dy;
    p   = 0;
    acc = 0;
    if (a == 0) return 0;
    if (s == 0) return RIGHT_DEG16;
    while (p < 29 && s < (64'd1 << (60 - 2 * p)) && a < (64'd1 << (39 - p))) p++;
    vx = longint'(isqrt(s << (2 * p)));
    vy = longint'(a << p);
    for (int i = 0; i < ATAN_STEPS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy > 0) begin
        vx  = vx + dx;
        vy  = vy - dy;
        acc = acc + longint'(ATAN_TAB[i]);
      end else begin
        vx  = vx - dx;
        vy  = vy + dy;
        acc = acc - longint'(ATAN_TAB[i]);
      end
    end
    if (acc < 0) return 0;
    if (acc > longint'(RIGHT_DEG16)) return RIGHT_DEG16;
    return longint'(acc);
  endfunction

  function automatic logic [OUT_W-1:0] round_signed(input longint unsigned mag16,
                                                   input bit negative);
    longint unsigned r;
    r = (mag16 + (64'd1 << (15 - ANGLE_FRAC_BITS))) >> (16 - ANGLE_FRAC_BITS);
    if (negative) r = -r;
    return r[OUT_W-1:0];
  endfunction

  function automatic tilt_t predict_tilt(input sample_t s);
    longint ax, ay, az;
    longint unsigned mx, my, mz, sx, sy, sz, tz;
    tilt_t t;
    ax = s.x;
    ay = s.y;
    az = s.z;
    mx = ax < 0 ? -ax : ax;
    my = ay < 0 ? -ay : ay;
    mz = az < 0 ? -az : az;
    sx = mx * mx;
    sy = my * my;
    sz = mz * mz;
    t.tx = round_signed(cordic_deg(mx, sy + sz), ax < 0);
    t.ty = round_signed(cordic_deg(my, sx + sz), ay < 0);
    if (mz == 0) tz = (sx + sy != 0) ? RIGHT_DEG16 : 0;
    else if (sx + sy == 0) tz = 0;
    else tz = RIGHT_DEG16 - cordic_deg(mz, sx + sy);
    t.tz = round_signed(tz, az < 0);
    return t;
  endfunction

  // request taken at the last rising edge
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_ch.valid && in_ch.ready;
  end

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid   <= 1'b0;
      in_ch.accel_x <= '0;
      in_ch.accel_y <= '0;
      in_ch.accel_z <= '0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_q.size() != 0 && $urandom_range(99, 0) >= idle_pct_in) begin
        in_ch.valid   <= 1'b1;
        in_ch.accel_x <= pending_q[0].x;
        in_ch.accel_y <= pending_q[0].y;
        in_ch.accel_z <= pending_q[0].z;
        void'(pending_q.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99, 0) >= idle_pct_out);
  end

  // monitor
  always @(posedge clk_i) begin
    tilt_t want, got;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        tilt_q.push_back(predict_tilt({in_ch.accel_x, in_ch.accel_y, in_ch.accel_z}));
        n_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.tilt_x, out_ch.tilt_y, out_ch.tilt_z};
        if (tilt_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result %p", got);
        end else begin
          want = tilt_q.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                       want.tx, want.ty, want.tz, got.tx, got.ty, got.tz);
          end
          n_checked++;
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog: no progress, %0d results outstanding", tilt_q.size());
      $display("FAIL accel_tilt_angles");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_field();
    case ($urandom_range(5, 0))
      0: return SAMPLE_WIDTH'(0);
      1: return SAMPLE_WIDTH'($urandom_range(3, 0)) - SAMPLE_WIDTH'(1);
      2: return $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
      3: return SAMPLE_WIDTH'($urandom_range(2000, 0)) - SAMPLE_WIDTH'(1000);
      default: return SAMPLE_WIDTH'($urandom());
    endcase
  endfunction

  task automatic run_phase(input int pin, input int pout, input int count);
    idle_pct_in  = pin;
    idle_pct_out = pout;
    for (int i = 0; i < count; i++)
      pending_q.push_back({rand_field(), rand_field(), rand_field()});
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    idle_pct_in  = 0;
    idle_pct_out = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_bad        = 0;
    quiet_cycles = 0;
    timed_out    = 1'b0;
    rst_ni       = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // zero over zero, divide by zero both signs, axis-aligned extremes
    pending_q.push_back({16'sd0, 16'sd0, 16'sd0});
    pending_q.push_back({16'sh7fff, 16'sd0, 16'sd0});
    pending_q.push_back({16'sh8000, 16'sd0, 16'sd0});
    pending_q.push_back({16'sd0, 16'sh7fff, 16'sd0});
    pending_q.push_back({16'sd0, 16'sh8000, 16'sd0});
    pending_q.push_back({16'sd0, 16'sd0, 16'sh7fff});
    pending_q.push_back({16'sd0, 16'sd0, 16'sh8000});
    pending_q.push_back({16'sh8000, 16'sh8000, 16'sh8000});
    pending_q.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff});
    pending_q.push_back({16'sd1, 16'sd1, 16'sd1});
    pending_q.push_back({-16'sd1, -16'sd1, -16'sd1});
    pending_q.push_back({16'sd1, 16'sh7fff, 16'sh8000});
    pending_q.push_back({16'sh8000, 16'sd1, -16'sd1});
    pending_q.push_back({16'sd1000, 16'sd0, 16'sd1000});
    pending_q.push_back({16'sh5555, 16'shaaaa, 16'sh5555});
    pending_q.push_back({16'shaaaa, 16'sh5555, 16'shaaaa});

    run_phase(0, 0, 400);
    run_phase(79, 0, 380);
    run_phase(0, 79, 380);
    run_phase(21, 21, 380);

    while (tilt_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("%0d samples sent, %0d results checked across four idling phases,",
             n_sent, n_checked);
    $display("including zero, full-scale and divide-by-zero samples");
    if (n_bad == 0 && tilt_q.size() == 0) begin
      $display("PASS accel_tilt_angles");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("FAIL accel_tilt_angles");
    end
    $finish;
  end

endmodule

// ===== accel_tilt_angles.f =====
hdl/att_pkg.sv
hdl/att_ifs.sv
hdl/att_front.sv
hdl/att_sqrt.sv
hdl/att_cordic.sv
hdl/accel_tilt_angles.sv
hdl/att_checker.sv
tb/tb_accel_tilt_angles.sv
